// ===== rtl/exposure_gain_to_sensor_codes_assert.svh =====
// Assertion macros for the exposure-to-sensor-code RTL.
`ifndef EXPOSURE_GAIN_TO_SENSOR_CODES_ASSERT_SVH
`define EXPOSURE_GAIN_TO_SENSOR_CODES_ASSERT_SVH

`ifndef SYNTHESIS

`define EGSC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

`define EGSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define EGSC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define EGSC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/egsc_pkg.sv =====
// Types and constants for the exposure-to-sensor-code converter.
`timescale 1ns / 1ps

package egsc_pkg;

   localparam int unsigned EXP_W   = 22;
   localparam int unsigned GAIN_W  = 20;
   localparam int unsigned LINES_W = 18;
   localparam int unsigned RESID_W = 12;
   localparam int unsigned COMP_W  = 22;
   localparam int unsigned CODE_W  = 7;

   // Shared serial divider: 32-bit dividend, 23-bit divisor.
   localparam int unsigned DIV_NUM_W = 32;
   localparam int unsigned DIV_DEN_W = 23;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic [DIV_DEN_W-1:0] LINE_TIME_CENTI_US = 23'd2963;
   localparam logic [DIV_DEN_W-1:0] CENTI              = 23'd100;
   localparam logic [RESID_W-1:0]   Q10_ONE            = 12'd1024;
   localparam logic [COMP_W-1:0]    GAIN_MIN_Q10       = 22'd1024;
   localparam logic [COMP_W-1:0]    GAIN_MAX_Q10       = 22'(248 * 1024);

   typedef struct packed {
      logic [EXP_W-1:0]  exposure_us;
      logic [GAIN_W-1:0] requested_gain_q10;
   } egsc_req_type;

   typedef struct packed {
      logic [LINES_W-1:0] exposure_lines;
      logic [RESID_W-1:0] residual_factor_q10;
      logic [COMP_W-1:0]  compensated_gain_q10;
      logic [CODE_W-1:0]  analog_gain_code;
   } egsc_rsp_type;

endpackage

// ===== rtl/egsc_stream_if.sv =====
// Valid/ready stream interface carrying one payload struct per transaction.
`timescale 1ns / 1ps

interface egsc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/egsc_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per clock while busy.
`timescale 1ns / 1ps

module egsc_serial_div import egsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;

   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W+1:0] diff;
   logic                 fits;

   // The dividend shifts out of the top of quo_ff while quotient bits enter at the bottom.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~diff[DIV_DEN_W+1];
      rem_in  = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/egsc_gain_code.sv =====
// Clamps a Q10 gain to 1x..248x and encodes exponent and sixteenths mantissa.
`timescale 1ns / 1ps

module egsc_gain_code import egsc_pkg::*; (
   input  logic [COMP_W-1:0] comp_gain,
   output logic [CODE_W-1:0] gain_code
);

   logic [COMP_W-1:0] clamped;
   logic [11:0]       steps;
   logic [6:0]        coarse;
   logic [2:0]        expo;
   logic [11:0]       norm;

   always_comb begin
      if (comp_gain > GAIN_MAX_Q10) begin
         clamped = GAIN_MAX_Q10;
      end else if (comp_gain < GAIN_MIN_Q10) begin
         clamped = GAIN_MIN_Q10;
      end else begin
         clamped = comp_gain;
      end
      // Gain in sixteenths of 1x; the clamp keeps it within 16..3968.
      steps  = clamped[17:6];
      coarse = steps[11:5];
      expo   = '0;
      for (int i = 0; i < 7; i++) begin
         if (coarse[i]) begin
            expo = 3'(i + 1);
         end
      end
      // After the shift the value lies in 16..31, so its low nibble is the mantissa.
      norm      = steps >> expo;
      gain_code = {expo, norm[3:0]};
   end

endmodule

// ===== rtl/exposure_gain_to_sensor_codes.sv =====
// Top level: converts an exposure request into line count, residual and gain code.
//
//   channel    direction  payload
//   req_chan   in         exposure_us, requested_gain_q10
//   rsp_chan   out        exposure_lines, residual_factor_q10,
//                         compensated_gain_q10, analog_gain_code
//
// Each transaction runs three divisions in turn on one bit-serial divider,
// then a multiply step (S_GAIN) and an encoding step (S_CODE) that loads
// the result into the output register when it is empty or being taken.
// Synchronous active-high reset clears the sequencer and the output valid flag.
// A new request is accepted once the previous result sits in the output register,
// even while the sink still stalls it.
`timescale 1ns / 1ps
`include "exposure_gain_to_sensor_codes_assert.svh"

module exposure_gain_to_sensor_codes import egsc_pkg::*; (
   input logic           clock,
   input logic           reset,
   egsc_stream_if.sink   req_chan,
   egsc_stream_if.source rsp_chan
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LINES   = 3'd1;
   localparam logic [2:0] S_LINE_US = 3'd2;
   localparam logic [2:0] S_RESID   = 3'd3;
   localparam logic [2:0] S_GAIN    = 3'd4;
   localparam logic [2:0] S_CODE    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [EXP_W-1:0]     exp_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [LINES_W-1:0]   lines_ff;
   logic [RESID_W-1:0]   resid_ff;
   logic [COMP_W-1:0]    comp_ff, comp_in;
   logic                 rsp_valid_ff;
   egsc_rsp_type         rsp_data_ff;

   logic                 accept;
   logic                 rsp_load;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic [LINES_W-1:0]   lines_sel;
   logic [RESID_W-1:0]   resid_sel;
   logic [DIV_NUM_W-1:0] gain_prod;
   logic [CODE_W-1:0]    gain_code;

   egsc_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   egsc_gain_code u_code (
      .comp_gain (comp_ff),
      .gain_code (gain_code)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Fewer than one whole line still integrates for one line.
   assign lines_sel = (div_quo == '0) ? LINES_W'(1) : div_quo[LINES_W-1:0];
   assign resid_sel = (div_quo < DIV_NUM_W'(Q10_ONE)) ? Q10_ONE : div_quo[RESID_W-1:0];
   assign gain_prod = DIV_NUM_W'(gain_ff) * DIV_NUM_W'(resid_ff);
   assign comp_in   = gain_prod[DIV_NUM_W-1:10];

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(req_chan.payload.exposure_us) * DIV_NUM_W'(CENTI);
               div_den   = LINE_TIME_CENTI_US;
               state_in  = S_LINES;
            end
         end
         S_LINES: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(lines_sel) * DIV_NUM_W'(LINE_TIME_CENTI_US);
               div_den   = CENTI;
               state_in  = S_LINE_US;
            end
         end
         S_LINE_US: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = {exp_ff, 10'b0};
               div_den   = div_quo[DIV_DEN_W-1:0];
               state_in  = S_RESID;
            end
         end
         S_RESID: begin
            if (div_done) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            state_in = S_CODE;
         end
         S_CODE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         exp_ff  <= req_chan.payload.exposure_us;
         gain_ff <= req_chan.payload.requested_gain_q10;
      end
      if (state_ff == S_LINES && div_done) begin
         lines_ff <= lines_sel;
      end
      if (state_ff == S_RESID && div_done) begin
         resid_ff <= resid_sel;
      end
      if (state_ff == S_GAIN) begin
         comp_ff <= comp_in;
      end
      if (rsp_load) begin
         rsp_data_ff.exposure_lines       <= lines_ff;
         rsp_data_ff.residual_factor_q10  <= resid_ff;
         rsp_data_ff.compensated_gain_q10 <= comp_ff;
         rsp_data_ff.analog_gain_code     <= gain_code;
      end
   end

   `EGSC_ASSERT_IMPL(a_div_done_in_div_state, clock, reset, div_done, (state_ff == S_LINES || state_ff == S_LINE_US || state_ff == S_RESID))
   `EGSC_ASSERT_NEXT(a_accept_starts_lines, clock, reset, accept, (state_ff == S_LINES))
   `EGSC_ASSERT_IMPL(a_rsp_fields_in_range, clock, reset, rsp_valid_ff, (rsp_data_ff.exposure_lines != '0 && rsp_data_ff.residual_factor_q10 >= Q10_ONE))

endmodule

// ===== dv/egsc_settings_checker.sv =====
// Checker for the exposure-to-sensor-code converter: predicts and compares every transaction.
`timescale 1ns / 1ps

module egsc_settings_checker import egsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  egsc_req_type req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  egsc_rsp_type rsp_payload,
   output int           mismatch_count,
   output int           settings_pending
);

   localparam longint unsigned LINE_CENTI_US = 2963;
   localparam longint unsigned CENTI_PER_US  = 100;
   localparam longint unsigned UNITY_Q10     = 1024;
   localparam longint unsigned CEILING_Q10   = 248 * 1024;
   localparam longint unsigned MANT_UNITY    = 16;

   egsc_rsp_type expected_settings_q[$];

   // Line count, residual factor, compensated gain and gain code for one request.
   function automatic egsc_rsp_type sensor_settings_for(egsc_req_type request);
      longint unsigned lines;
      longint unsigned line_span_us;
      longint unsigned residual;
      longint unsigned compensated;
      longint unsigned clamped;
      longint unsigned sixteenths;
      longint unsigned high_part;
      int unsigned     exponent;
      egsc_rsp_type    settings;
      lines = longint'(request.exposure_us) * CENTI_PER_US / LINE_CENTI_US;
      if (lines == 0)
         lines = 1;
      line_span_us = lines * LINE_CENTI_US / CENTI_PER_US;
      residual = longint'(request.exposure_us) * UNITY_Q10 / line_span_us;
      if (residual < UNITY_Q10)
         residual = UNITY_Q10;
      compensated = longint'(request.requested_gain_q10) * residual / UNITY_Q10;
      clamped = compensated;
      if (clamped > CEILING_Q10)
         clamped = CEILING_Q10;
      if (clamped < UNITY_Q10)
         clamped = UNITY_Q10;
      sixteenths = (clamped * MANT_UNITY) >> 10;
      // The exponent is the bit length of the sixteenths count over 32.
      high_part = sixteenths / 32;
      exponent = 0;
      while (high_part != 0) begin
         high_part = high_part >> 1;
         exponent++;
      end
      settings.exposure_lines       = lines[LINES_W-1:0];
      settings.residual_factor_q10  = residual[RESID_W-1:0];
      settings.compensated_gain_q10 = compensated[COMP_W-1:0];
      settings.analog_gain_code     = {exponent[2:0], 4'((sixteenths >> exponent) - MANT_UNITY)};
      return settings;
   endfunction

   function automatic void compare_field(string field, longint unsigned want,
                                         longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin
      mismatch_count   = 0;
      settings_pending = 0;
   end

   always @(posedge clock) begin
      egsc_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_settings_q.push_back(sensor_settings_for(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_settings_q.size() == 0) begin
               $error("result transaction arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_settings_q.pop_front();
               compare_field("exposure_lines", want.exposure_lines,
                             rsp_payload.exposure_lines);
               compare_field("residual_factor_q10", want.residual_factor_q10,
                             rsp_payload.residual_factor_q10);
               compare_field("compensated_gain_q10", want.compensated_gain_q10,
                             rsp_payload.compensated_gain_q10);
               compare_field("analog_gain_code", want.analog_gain_code,
                             rsp_payload.analog_gain_code);
            end
         end
         settings_pending = expected_settings_q.size();
      end
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the exposure-to-sensor-code converter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb import egsc_pkg::*;;

   localparam int RANDOM_REQUESTS = 550;
   localparam int QUIET_TAIL      = 80;
   localparam int DRAIN_CYCLES    = 120;

   logic clock;
   logic reset;
   int   idle_pct;
   int   mismatch_count;
   int   settings_pending;

   egsc_stream_if #(.payload_type(egsc_req_type)) req_chan ();
   egsc_stream_if #(.payload_type(egsc_rsp_type)) rsp_chan ();

   exposure_gain_to_sensor_codes dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   egsc_settings_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_payload      (req_chan.payload),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_payload      (rsp_chan.payload),
      .mismatch_count   (mismatch_count),
      .settings_pending (settings_pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic egsc_req_type make_request(longint unsigned exposure_us,
                                                 longint unsigned gain_q10);
      egsc_req_type request;
      request.exposure_us        = exposure_us[EXP_W-1:0];
      request.requested_gain_q10 = gain_q10[GAIN_W-1:0];
      return request;
   endfunction

   // Random requests weighted toward line boundaries, the clamp limits and exponent steps.
   function automatic egsc_req_type random_request();
      longint unsigned exposure_us;
      longint unsigned gain_q10;
      longint unsigned lines;
      int unsigned     shift;
      exposure_us = $urandom_range(0, 4194303);
      gain_q10    = $urandom_range(0, 1048575);
      case ($urandom_range(0, 5))
         0: ;
         1: exposure_us = $urandom_range(0, 120);
         2: begin
            exposure_us = $urandom_range(30, 40000);
            gain_q10    = $urandom_range(1024, 253952);
         end
         3: begin
            // Land just around the start of a whole line.
            lines = $urandom_range(1, 141550);
            exposure_us = (lines * 2963 + 99) / 100 + $urandom_range(0, 2) - 1;
         end
         4: begin
            if ($urandom_range(0, 1) == 0)
               gain_q10 = $urandom_range(240000, 270000);
            else
               gain_q10 = $urandom_range(900, 1100);
         end
         default: begin
            shift = $urandom_range(0, 7);
            gain_q10 = (longint'(1024) << shift) + $urandom_range(0, 8) - 4;
            exposure_us = $urandom_range(0, 3000);
         end
      endcase
      return make_request(exposure_us, gain_q10);
   endfunction

   task automatic offer_request(egsc_req_type request);
      req_chan.payload <= request;
      req_chan.valid   <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Result side: stalls in bursts at the current idle rate.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && $urandom_range(0, 99) < idle_pct) begin
            rsp_chan.ready <= 1'b0;
            // The loop's own edge also falls within this stalled burst.
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      egsc_req_type directed_q[$];
      directed_q = '{
         make_request(0, 0),
         make_request(0, 1048575),
         make_request(1, 1024),
         make_request(28, 5000),
         make_request(29, 1023),
         make_request(30, 1024),
         make_request(44, 2048),
         make_request(59, 2047),
         make_request(59, 253952),
         make_request(60, 253953),
         make_request(2963, 4096),
         make_request(2964, 8191),
         make_request(33333, 16384),
         make_request(100000, 65535),
         make_request(4194303, 0),
         make_request(4194303, 1048575),
         make_request(4194302, 131072),
         make_request(1000, 1048575),
         make_request(200, 1),
         make_request(150, 253951)
      };
      idle_pct         = 0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[i])
         offer_request(directed_q[i]);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i < 150)
            idle_pct = 30;
         else if (i < 300)
            idle_pct = 10;
         else if (i < RANDOM_REQUESTS - QUIET_TAIL)
            idle_pct = 50;
         else
            idle_pct = 0;
         offer_request(random_request());
      end
      req_chan.valid <= 1'b0;
      // Let the checker record the last request before polling its count.
      @(posedge clock);

      while (settings_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && settings_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Generous bound: a few times the slowest correct run.
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
